@@ src/sard_pkg.sv @@
// Shared constants and types for the sorted address range decoder.
`default_nettype none
package sard_pkg;

    localparam int MAX_RANGES = 16;
    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int AW = 32;
    localparam int TW = 8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_OVERLAP  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_BADRANGE = 3'd4;

    typedef struct packed {
        logic [AW-1:0] first;
        logic [AW-1:0] last;
        logic [TW-1:0] tag;
    } t_entry;

endpackage
`default_nettype wire

@@ src/sorted_address_range_decoder_top.sv @@
// Sorted address range decoder: sequencer, binary search and output register.
// Lookup: a binary search over the ranges held, then S_CHECK and S_FINISH.
// Insert: a range check in S_RANGE first; a bad range skips the search and goes to S_FINISH.
// One item at a time: the next item can be taken in the cycle after the result is
// registered. The search steps share a single 32-bit comparator.
// Reset clears the entry count and the handshake; table contents are not cleared.
`default_nettype none
module sorted_address_range_decoder_top
    import sard_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic          i_action,
    input  wire logic [31:0]   i_address,
    input  wire logic [31:0]   i_range_end,
    input  wire logic [7:0]    i_device_tag,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [2:0]         o_status,
    output logic [7:0]         o_found_tag,
    output logic [4:0]         o_entries_used
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_SEARCH,
        S_CHECK,
        S_FINISH
    } t_state;

    t_state        r_state, n_state;
    logic          r_action, n_action;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_last, n_last;
    logic [AW-1:0] r_key, n_key;
    logic [TW-1:0] r_tag, n_tag;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_count, n_count;
    logic [2:0]    r_res_status, n_res_status;
    logic [TW-1:0] r_res_tag, n_res_tag;
    logic          r_out_valid, n_out_valid;
    logic [2:0]    r_status, n_status;
    logic [TW-1:0] r_found_tag, n_found_tag;
    logic [4:0]    r_entries, n_entries;

    logic [CW:0]   w_sum;
    logic [CW-1:0] w_mid;
    logic [CW-1:0] w_prev;
    logic [IW-1:0] w_rd_idx;
    t_entry        w_rd;
    logic [AW-1:0] w_cmp_a;
    logic [AW-1:0] w_cmp_b;
    logic          w_le;
    logic          w_hit;
    logic          w_full;
    logic          w_wr_en;
    t_entry        w_wr_entry;

    assign w_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid  = w_sum[CW:1];
    assign w_prev = r_lo - CW'(1);
    assign w_rd_idx = (r_state == S_SEARCH) ? w_mid[IW-1:0] : w_prev[IW-1:0];
    assign w_full = (r_count == CW'(MAX_RANGES));
    // The candidate is the last range starting at or below the key; since ranges
    // are disjoint and sorted, it alone can hold the address or overlap.
    assign w_hit  = (r_lo != '0) && w_le;

    assign w_wr_entry.first = r_addr;
    assign w_wr_entry.last  = r_last;
    assign w_wr_entry.tag   = r_tag;

    always_comb begin
        case (r_state)
            S_RANGE: begin
                w_cmp_a = r_addr;
                w_cmp_b = r_last;
            end
            S_SEARCH: begin
                w_cmp_a = w_rd.first;
                w_cmp_b = r_key;
            end
            default: begin
                w_cmp_a = r_addr;
                w_cmp_b = w_rd.last;
            end
        endcase
    end

    sard_cmp u_cmp (
        .i_a  (w_cmp_a),
        .i_b  (w_cmp_b),
        .o_le (w_le)
    );

    sard_table u_table (
        .i_clk      (i_clk),
        .i_rd_idx   (w_rd_idx),
        .o_rd       (w_rd),
        .i_wr_en    (w_wr_en),
        .i_wr_pos   (r_lo[IW-1:0]),
        .i_wr_entry (w_wr_entry)
    );

    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_addr       = r_addr;
        n_last       = r_last;
        n_key        = r_key;
        n_tag        = r_tag;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_tag    = r_res_tag;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_found_tag  = r_found_tag;
        n_entries    = r_entries;
        w_wr_en      = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_action = i_action;
                    n_addr   = i_address;
                    n_last   = i_range_end;
                    n_tag    = i_device_tag;
                    n_key    = i_action ? i_address : i_range_end;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_state  = i_action ? S_SEARCH : S_RANGE;
                end
            end
            S_RANGE: begin
                if (w_le) begin
                    n_state = S_SEARCH;
                end else begin
                    n_res_status = ST_BADRANGE;
                    n_res_tag    = '0;
                    n_state      = S_FINISH;
                end
            end
            S_SEARCH: begin
                // Narrow [lo, hi) to the count of ranges starting at or below the key.
                if (r_lo == r_hi) begin
                    n_state = S_CHECK;
                end else if (w_le) begin
                    n_lo = w_mid + CW'(1);
                end else begin
                    n_hi = w_mid;
                end
            end
            S_CHECK: begin
                n_res_tag = '0;
                if (r_action) begin
                    n_res_status = w_hit ? ST_OK : ST_MISS;
                    if (w_hit) begin
                        n_res_tag = w_rd.tag;
                    end
                end else if (w_hit) begin
                    n_res_status = ST_OVERLAP;
                end else if (w_full) begin
                    n_res_status = ST_FULL;
                end else begin
                    n_res_status = ST_OK;
                    n_count      = r_count + CW'(1);
                    w_wr_en      = 1'b1;
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_found_tag = r_res_tag;
                    n_entries   = 5'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_action     <= n_action;
        r_addr       <= n_addr;
        r_last       <= n_last;
        r_key        <= n_key;
        r_tag        <= n_tag;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_res_status <= n_res_status;
        r_res_tag    <= n_res_tag;
        r_status     <= n_status;
        r_found_tag  <= n_found_tag;
        r_entries    <= n_entries;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_found_tag    = r_found_tag;
    assign o_entries_used = r_entries;

endmodule
`default_nettype wire

@@ src/sard_cmp.sv @@
// Shared unsigned compare unit used by the range check, search and check steps of the sequencer.
`default_nettype none
module sard_cmp
    import sard_pkg::*;
(
    input  wire logic [AW-1:0] i_a,
    input  wire logic [AW-1:0] i_b,
    output logic               o_le
);

    assign o_le = (i_a <= i_b);

endmodule
`default_nettype wire

@@ src/sard_table.sv @@
// Sorted range table with one read port and a shifting insert.
`default_nettype none
module sard_table
    import sard_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic [IW-1:0] i_rd_idx,
    output t_entry             o_rd,
    input  wire logic          i_wr_en,
    input  wire logic [IW-1:0] i_wr_pos,
    input  wire t_entry        i_wr_entry
);

    t_entry r_tab [MAX_RANGES];

    // Every entry above the insert position moves up by one; the new range
    // lands at the insert position.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int i = 1; i < MAX_RANGES; i++) begin
                if (IW'(i) > i_wr_pos) begin
                    r_tab[i] <= r_tab[i-1];
                end
            end
            r_tab[i_wr_pos] <= i_wr_entry;
        end
    end

    assign o_rd = r_tab[i_rd_idx];

endmodule
`default_nettype wire

@@ test/sorted_address_range_decoder_top_tb.sv @@
// Self-checking testbench for the sorted address range decoder: directed and random items.
module sorted_address_range_decoder_top_tb;
    import sard_pkg::*;

    localparam bit ACT_INSERT = 1'b0;
    localparam bit ACT_LOOKUP = 1'b1;
    localparam int RANDOM_ITEMS = 1800;
    localparam int STEADY_FIRST = 700;
    localparam int STEADY_LAST = 1000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [2:0] status;
        logic [7:0] found_tag;
        logic [4:0] entries_used;
    } decode_answer_t;

    class range_decoder_checker;
        bit [31:0] range_first[MAX_RANGES];
        bit [31:0] range_last[MAX_RANGES];
        bit [7:0] range_tag[MAX_RANGES];
        int unsigned range_count;
        decode_answer_t pending_answers[$];
        int unsigned mismatches;
        int unsigned inserts;
        int unsigned lookups;
        int unsigned status_hits[5];

        // Updates the copy of the table and queues the answer the block owes.
        function void note_item(bit act, bit [31:0] addr, bit [31:0] last, bit [7:0] tag);
            decode_answer_t ans;
            int unsigned pos;
            ans.found_tag = 8'h00;
            if (act == ACT_LOOKUP) begin
                lookups++;
                ans.status = ST_MISS;
                for (int i = 0; i < int'(range_count); i++) begin
                    if (ans.status == ST_MISS && addr >= range_first[i] && addr <= range_last[i]) begin
                        ans.status = ST_OK;
                        ans.found_tag = range_tag[i];
                    end
                end
            end else begin
                inserts++;
                ans.status = ST_OK;
                if (addr > last) begin
                    ans.status = ST_BADRANGE;
                end else begin
                    for (int i = 0; i < int'(range_count); i++) begin
                        if (!(range_last[i] < addr || range_first[i] > last))
                            ans.status = ST_OVERLAP;
                    end
                    if (ans.status == ST_OK && range_count == MAX_RANGES)
                        ans.status = ST_FULL;
                end
                if (ans.status == ST_OK) begin
                    // The new range goes before the first entry that starts above it.
                    pos = range_count;
                    for (int i = int'(range_count) - 1; i >= 0; i--) begin
                        if (range_first[i] > last)
                            pos = i;
                    end
                    for (int i = int'(range_count); i > int'(pos); i--) begin
                        range_first[i] = range_first[i-1];
                        range_last[i] = range_last[i-1];
                        range_tag[i] = range_tag[i-1];
                    end
                    range_first[pos] = addr;
                    range_last[pos] = last;
                    range_tag[pos] = tag;
                    range_count++;
                end
            end
            ans.entries_used = 5'(range_count);
            status_hits[ans.status]++;
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(logic [2:0] status, logic [7:0] tag, logic [4:0] used);
            decode_answer_t want;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result status=%0d tag=%02h used=%0d",
                             status, tag, used);
                return;
            end
            want = pending_answers.pop_front();
            if (status !== want.status || tag !== want.found_tag ||
                used !== want.entries_used) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: expected status=%0d tag=%02h used=%0d, got status=%0d tag=%02h used=%0d",
                             want.status, want.found_tag, want.entries_used, status, tag, used);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic i_action;
    logic [31:0] i_address;
    logic [31:0] i_range_end;
    logic [7:0] i_device_tag;
    logic o_valid;
    logic i_stall;
    logic [2:0] o_status;
    logic [7:0] o_found_tag;
    logic [4:0] o_entries_used;

    range_decoder_checker sb;
    bit steady;
    int unsigned idle_cycles;

    sorted_address_range_decoder_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_address      (i_address),
        .i_range_end    (i_range_end),
        .i_device_tag   (i_device_tag),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_found_tag    (o_found_tag),
        .o_entries_used (o_entries_used)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= !steady && ($urandom_range(0, 99) < 29);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_answer(o_status, o_found_tag, o_entries_used);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic bit [31:0] sat_add(bit [31:0] a, bit [31:0] b);
        return (a > 32'hFFFF_FFFF - b) ? 32'hFFFF_FFFF : a + b;
    endfunction

    // Random address inside stored entry k; a range may span the whole space.
    function automatic bit [31:0] point_in(int unsigned k);
        bit [32:0] width;
        width = {1'b0, sb.range_last[k]} - {1'b0, sb.range_first[k]} + 33'd1;
        return sb.range_first[k] + 32'({$urandom, $urandom} % width);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(bit act, bit [31:0] addr, bit [31:0] last, bit [7:0] tag);
        while (!steady && $urandom_range(0, 99) < 29) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_address <= addr;
        i_range_end <= last;
        i_device_tag <= tag;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_item(act, addr, last, tag);
        @(negedge i_clk);
    endtask

    // Mostly ranges that fit, touch or overlap what is stored, plus lookups near entries.
    task automatic make_random_item(output bit act, output bit [31:0] addr,
                                    output bit [31:0] last, output bit [7:0] tag);
        int unsigned roll;
        int unsigned pick;
        bit [31:0] span;
        bit [31:0] p;
        roll = $urandom_range(0, 99);
        tag = 8'($urandom);
        addr = $urandom;
        last = $urandom;
        pick = (sb.range_count > 0) ? $urandom_range(0, sb.range_count - 1) : 0;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32'h00FF_FFFF)
                                           : $urandom_range(0, 255);
        if (roll < 35) begin
            act = ACT_INSERT;
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                last = sat_add(addr, span);
            end else if (roll < 60 && sb.range_count > 0) begin
                if ($urandom_range(0, 1)) begin
                    addr = sb.range_last[pick] + 32'd1;
                    last = sat_add(addr, {28'd0, span[3:0]});
                end else begin
                    last = sb.range_first[pick] - 32'd1;
                    addr = (last > span) ? last - span : 32'd0;
                end
            end else if (roll < 80 && sb.range_count > 0) begin
                p = point_in(pick);
                addr = $urandom_range(0, 1) ? p : ((p > span) ? p - span : 32'd0);
                last = $urandom_range(0, 1) ? p : sat_add(p, span);
            end else if (roll < 92) begin
                if (addr < last)
                    {addr, last} = {last, addr};
            end
        end else begin
            act = ACT_LOOKUP;
            roll = $urandom_range(0, 99);
            if (roll < 55 && sb.range_count > 0) begin
                case ($urandom_range(0, 2))
                    0: addr = sb.range_first[pick];
                    1: addr = sb.range_last[pick];
                    default: addr = point_in(pick);
                endcase
            end else if (roll < 70 && sb.range_count > 0) begin
                addr = $urandom_range(0, 1) ? sb.range_first[pick] - 32'd1
                                            : sb.range_last[pick] + 32'd1;
            end
        end
    endtask

    initial begin
        bit act;
        bit [31:0] addr;
        bit [31:0] last;
        bit [7:0] tag;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = ACT_INSERT;
        i_address = 32'd0;
        i_range_end = 32'd0;
        i_device_tag = 8'd0;
        i_stall = 1'b0;
        steady = 1'b0;
        idle_cycles = 0;
        sb = new;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, bad ranges, inserts that shift entries, overlaps, edge lookups.
        send_item(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'h00);
        send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_item(ACT_INSERT, 32'h0000_0001, 32'h0000_0000, 8'h11);
        send_item(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 8'h22);
        send_item(ACT_INSERT, 32'h0000_0000, 32'h0000_0000, 8'hFF);
        send_item(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
        send_item(ACT_INSERT, 32'h8000_0000, 32'h8000_FFFF, 8'hA5);
        send_item(ACT_INSERT, 32'h0000_1000, 32'h0000_1FFF, 8'h5A);
        send_item(ACT_INSERT, 32'h0000_2000, 32'h0000_2000, 8'h3C);
        send_item(ACT_INSERT, 32'h8000_FFFF, 32'h9000_0000, 8'h01);
        send_item(ACT_INSERT, 32'h0000_0000, 32'h0000_0010, 8'h02);
        send_item(ACT_INSERT, 32'h0000_1100, 32'h0000_1100, 8'h03);
        send_item(ACT_INSERT, 32'h8000_1000, 32'h8000_0001, 8'h04);
        send_item(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 8'h05);
        send_item(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'h00);
        send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
        send_item(ACT_LOOKUP, 32'h8000_0000, 32'h0000_0000, 8'h00);
        send_item(ACT_LOOKUP, 32'h8000_FFFF, 32'h0000_0000, 8'h00);
        send_item(ACT_LOOKUP, 32'h8001_0000, 32'h0000_0000, 8'h00);
        send_item(ACT_LOOKUP, 32'h0000_0FFF, 32'h0000_0000, 8'h00);
        send_item(ACT_LOOKUP, 32'h0000_1800, 32'hFFFF_FFFF, 8'hFF);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= STEADY_FIRST && n < STEADY_LAST);
            make_random_item(act, addr, last, tag);
            send_item(act, addr, last, tag);
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        while (sb.pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d inserts and %0d lookups; table ended with %0d of %0d ranges.",
                 sb.inserts, sb.lookups, sb.range_count, MAX_RANGES);
        $display("Answers: %0d ok or hit, %0d miss, %0d overlap, %0d full, %0d bad range; %0d mismatches.",
                 sb.status_hits[ST_OK], sb.status_hits[ST_MISS], sb.status_hits[ST_OVERLAP],
                 sb.status_hits[ST_FULL], sb.status_hits[ST_BADRANGE], sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_answers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
